// File: hdl/rmq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the rotation matrix to quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_W = 16;
  localparam int QUOT_W = 16;

  localparam logic signed [DATA_W-1:0] OUT_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] OUT_MIN = 16'sh8000;

  // output component that takes the square root
  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2,
    COMP_W = 2'd3
  } comp_t;

endpackage
`default_nettype wire

// File: hdl/rotation_matrix_to_quaternion.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Fixed point rotation matrix to unit quaternion, fully pipelined.
// ----------------------------------------------------------------------------
// Input channel: nine matrix entries m00..m22 with in_valid / in_ready.
// Output channel: quat_x, quat_y, quat_z, quat_w and invalid with
// out_valid / out_ready. A beat moves when valid and ready are both high.
// SW is the root width (17 for FRAC_BITS = 14). Throughput is one beat per
// cycle while out_ready is high: one register stage per root bit of the
// square root pipeline, then one per quotient bit of the four-lane divider
// pipeline. Every stage carries its own valid bit and holds when the next
// stage is full and stalled, so a stalled receiver fills the pipe from the
// end without losing or repeating a beat; in_ready drops only when every
// stage is full. Bubbles close up as the receiver stays stalled.
// Synchronous reset clears all valid bits; the pipe is empty after reset.
// When the pivot radicand is not positive, invalid is set and all four
// components are zero.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  signed [DATA_W-1:0]  m00,
  input  wire  signed [DATA_W-1:0]  m01,
  input  wire  signed [DATA_W-1:0]  m02,
  input  wire  signed [DATA_W-1:0]  m10,
  input  wire  signed [DATA_W-1:0]  m11,
  input  wire  signed [DATA_W-1:0]  m12,
  input  wire  signed [DATA_W-1:0]  m20,
  input  wire  signed [DATA_W-1:0]  m21,
  input  wire  signed [DATA_W-1:0]  m22,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic signed [DATA_W-1:0]  quat_x,
  output logic signed [DATA_W-1:0]  quat_y,
  output logic signed [DATA_W-1:0]  quat_z,
  output logic signed [DATA_W-1:0]  quat_w,
  output logic                      invalid
);

  localparam int RW  = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  localparam int NW  = RW + FRAC_BITS;
  localparam int NW2 = NW + (NW % 2);
  localparam int SW  = NW2 / 2;
  localparam int QW  = NW2 + 2;
  localparam int DW  = 18;
  localparam int MW  = 17;
  localparam int CW  = SW + QUOT_W + 2;
  localparam int NS  = SW + QUOT_W + 3;
  localparam int S_SETUP = SW + 1;
  localparam int S_LAST  = NS - 1;

  // per-stage registers
  logic                  vld   [NS];
  logic                  bad   [NS];
  comp_t                 rsel  [NS];
  logic signed [DW-1:0]  dif   [NS][4];
  logic [QW-1:0]         sq_rem  [NS];
  logic [SW-1:0]         sq_root [NS];
  logic [CW-1:0]         dvs   [NS];
  logic [DATA_W-1:0]     half  [NS];
  logic [CW-1:0]         dv_rem [NS][4];
  logic [QUOT_W-1:0]     dv_q   [NS][4];
  logic                  neg    [NS][4];
  logic                  ovf    [NS][4];
  logic signed [DATA_W-1:0] res [NS][4];
  logic                  adv   [NS];

  // front end: trace, pivot, radicand and the three numerators
  logic signed [DW-1:0]  trace;
  logic                  trace_pos;
  logic [1:0]            piv;
  logic signed [RW:0]    rad_s;
  logic signed [RW:0]    one_s;
  logic                  bad_in;
  comp_t                 rsel_in;
  logic signed [DW-1:0]  dif_in [4];

  always_comb begin
    one_s = (RW+1)'(1) <<< FRAC_BITS;
    trace = DW'(m00) + DW'(m11) + DW'(m22);
    trace_pos = (trace > 0);
    piv = 2'd0;
    if (m11 > m00) piv = 2'd1;
    if (m22 > ((piv == 2'd1) ? m11 : m00)) piv = 2'd2;
    for (int n = 0; n < 4; n++) dif_in[n] = '0;
    rad_s = '0;
    rsel_in = COMP_W;
    if (trace_pos) begin
      rad_s = (RW+1)'(trace) + one_s;
      dif_in[COMP_X] = DW'(m21) - DW'(m12);
      dif_in[COMP_Y] = DW'(m02) - DW'(m20);
      dif_in[COMP_Z] = DW'(m10) - DW'(m01);
    end else begin
      case (piv)
        2'd0: begin
          rsel_in = COMP_X;
          rad_s = (RW+1)'(m00) - (RW+1)'(m11) - (RW+1)'(m22) + one_s;
          dif_in[COMP_W] = DW'(m21) - DW'(m12);
          dif_in[COMP_Y] = DW'(m10) + DW'(m01);
          dif_in[COMP_Z] = DW'(m20) + DW'(m02);
        end
        2'd1: begin
          rsel_in = COMP_Y;
          rad_s = (RW+1)'(m11) - (RW+1)'(m22) - (RW+1)'(m00) + one_s;
          dif_in[COMP_W] = DW'(m02) - DW'(m20);
          dif_in[COMP_Z] = DW'(m21) + DW'(m12);
          dif_in[COMP_X] = DW'(m01) + DW'(m10);
        end
        default: begin
          rsel_in = COMP_Z;
          rad_s = (RW+1)'(m22) - (RW+1)'(m00) - (RW+1)'(m11) + one_s;
          dif_in[COMP_W] = DW'(m10) - DW'(m01);
          dif_in[COMP_X] = DW'(m02) + DW'(m20);
          dif_in[COMP_Y] = DW'(m12) + DW'(m21);
        end
      endcase
    end
    bad_in = !trace_pos && (rad_s <= 0);
  end

  // stage advance chain
  always_comb begin
    adv[S_LAST] = !vld[S_LAST] || out_ready;
    for (int s = S_LAST - 1; s >= 0; s--) adv[s] = !vld[s] || adv[s+1];
  end

  assign in_ready = adv[0];

  genvar gs;
  generate
    for (gs = 0; gs < NS; gs++) begin : g_stage
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[gs] <= 1'b0;
        end else if (adv[gs]) begin
          vld[gs] <= (gs == 0) ? in_valid : vld[(gs == 0) ? 0 : gs-1];
        end
      end

      if (gs == 0) begin : g_prep
        always_ff @(posedge clk) begin
          if (adv[gs]) begin
            bad[gs]  <= bad_in;
            rsel[gs] <= rsel_in;
            for (int n = 0; n < 4; n++) dif[gs][n] <= dif_in[n];
            sq_rem[gs]  <= QW'(rad_s[RW-1:0]) << FRAC_BITS;
            sq_root[gs] <= '0;
          end
        end
      end else if (gs <= SW) begin : g_sqrt
        localparam int B = SW - gs;
        logic [QW-1:0] trial;
        always_comb begin
          trial = (QW'(sq_root[gs-1]) << (B + 1)) | (QW'(1) << (2 * B));
        end
        always_ff @(posedge clk) begin
          if (adv[gs]) begin
            bad[gs]  <= bad[gs-1];
            rsel[gs] <= rsel[gs-1];
            for (int n = 0; n < 4; n++) dif[gs][n] <= dif[gs-1][n];
            if (sq_rem[gs-1] >= trial) begin
              sq_rem[gs]  <= sq_rem[gs-1] - trial;
              sq_root[gs] <= sq_root[gs-1] | (SW'(1) << B);
            end else begin
              sq_rem[gs]  <= sq_rem[gs-1];
              sq_root[gs] <= sq_root[gs-1];
            end
          end
        end
      end else if (gs == S_SETUP) begin : g_setup
        logic [CW-1:0]        dv_c;
        logic [SW-1:0]        half_c;
        logic signed [DW:0]   ext [4];
        logic [MW-1:0]        mag [4];
        logic [CW-1:0]        num [4];
        always_comb begin
          dv_c = CW'({sq_root[gs-1], 1'b0});
          half_c = sq_root[gs-1] >> 1;
          for (int n = 0; n < 4; n++) begin
            ext[n] = (DW+1)'(dif[gs-1][n]);
            mag[n] = (ext[n] < 0) ? MW'(-ext[n]) : MW'(ext[n]);
            num[n] = CW'(mag[n]) << FRAC_BITS;
          end
        end
        always_ff @(posedge clk) begin
          if (adv[gs]) begin
            bad[gs]  <= bad[gs-1];
            rsel[gs] <= rsel[gs-1];
            dvs[gs]  <= dv_c;
            half[gs] <= (half_c > SW'(OUT_MAX)) ? DATA_W'(OUT_MAX) : DATA_W'(half_c);
            for (int n = 0; n < 4; n++) begin
              neg[gs][n]    <= dif[gs-1][n] < 0;
              ovf[gs][n]    <= num[n] >= (dv_c << QUOT_W);
              dv_rem[gs][n] <= num[n];
              dv_q[gs][n]   <= '0;
            end
          end
        end
      end else if (gs < S_LAST) begin : g_div
        localparam int B = QUOT_W - 1 - (gs - S_SETUP - 1);
        logic [CW-1:0] t;
        always_comb begin
          t = dvs[gs-1] << B;
        end
        always_ff @(posedge clk) begin
          if (adv[gs]) begin
            bad[gs]  <= bad[gs-1];
            rsel[gs] <= rsel[gs-1];
            dvs[gs]  <= dvs[gs-1];
            half[gs] <= half[gs-1];
            for (int n = 0; n < 4; n++) begin
              neg[gs][n] <= neg[gs-1][n];
              ovf[gs][n] <= ovf[gs-1][n];
              if (dv_rem[gs-1][n] >= t) begin
                dv_rem[gs][n] <= dv_rem[gs-1][n] - t;
                dv_q[gs][n]   <= dv_q[gs-1][n] | (QUOT_W'(1) << B);
              end else begin
                dv_rem[gs][n] <= dv_rem[gs-1][n];
                dv_q[gs][n]   <= dv_q[gs-1][n];
              end
            end
          end
        end
      end else begin : g_out
        logic signed [DATA_W-1:0] val [4];
        always_comb begin
          for (int n = 0; n < 4; n++) begin
            if (bad[gs-1]) begin
              val[n] = '0;
            end else if (rsel[gs-1] == comp_t'(n)) begin
              val[n] = half[gs-1];
            end else if (!neg[gs-1][n]) begin
              val[n] = (ovf[gs-1][n] || dv_q[gs-1][n] > QUOT_W'(OUT_MAX))
                       ? OUT_MAX : DATA_W'(dv_q[gs-1][n]);
            end else begin
              // magnitude 32768 still fits on the negative side
              val[n] = (ovf[gs-1][n] || dv_q[gs-1][n] > QUOT_W'(OUT_MIN))
                       ? OUT_MIN : DATA_W'(-dv_q[gs-1][n]);
            end
          end
        end
        always_ff @(posedge clk) begin
          if (adv[gs]) begin
            bad[gs] <= bad[gs-1];
            for (int n = 0; n < 4; n++) res[gs][n] <= val[n];
          end
        end
      end
    end
  endgenerate

  assign out_valid = vld[S_LAST];
  assign quat_x    = res[S_LAST][COMP_X];
  assign quat_y    = res[S_LAST][COMP_Y];
  assign quat_z    = res[S_LAST][COMP_Z];
  assign quat_w    = res[S_LAST][COMP_W];
  assign invalid   = bad[S_LAST];

  // a flagged beat carries zero components
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && invalid) |->
      (quat_x == 0 && quat_y == 0 && quat_z == 0 && quat_w == 0))
    else $error("invalid beat with nonzero components");

  // backpressure reaches the input only with a stalled, full output
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled while output not blocked");

  // pipe is empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire

// File: tb/sv/rmq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmq_checker
// Watches both channels of the matrix to quaternion block, predicts each
// quaternion from the accepted matrix and compares it field by field.
// ----------------------------------------------------------------------------
module rmq_checker
  import rmq_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      in_valid,
  input  wire                      in_ready,
  input  wire signed [DATA_W-1:0]  m00,
  input  wire signed [DATA_W-1:0]  m01,
  input  wire signed [DATA_W-1:0]  m02,
  input  wire signed [DATA_W-1:0]  m10,
  input  wire signed [DATA_W-1:0]  m11,
  input  wire signed [DATA_W-1:0]  m12,
  input  wire signed [DATA_W-1:0]  m20,
  input  wire signed [DATA_W-1:0]  m21,
  input  wire signed [DATA_W-1:0]  m22,
  input  wire                      out_valid,
  input  wire                      out_ready,
  input  wire signed [DATA_W-1:0]  quat_x,
  input  wire signed [DATA_W-1:0]  quat_y,
  input  wire signed [DATA_W-1:0]  quat_z,
  input  wire signed [DATA_W-1:0]  quat_w,
  input  wire                      invalid,
  output int                       fail_count,
  output int                       pending
);

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
    logic signed [DATA_W-1:0] w;
    logic                     bad;
  } quat_t;

  quat_t expected_quats[$];

  assign pending = expected_quats.size();

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic logic signed [DATA_W-1:0] clamp16(longint v);
    if (v > longint'(OUT_MAX)) return OUT_MAX;
    if (v < longint'(OUT_MIN)) return OUT_MIN;
    return v[DATA_W-1:0];
  endfunction

  // truncating divide of the scaled difference by twice the root
  function automatic longint scaled_div(longint d, longint s);
    return (d * (longint'(1) << FRAC_BITS)) / (2 * s);
  endfunction

  function automatic quat_t predict_quat(longint a[3][3]);
    quat_t res;
    longint comp[4];
    longint tr, rad, s;
    int i, j, k;
    res = '0;
    comp = '{0, 0, 0, 0};
    tr = a[0][0] + a[1][1] + a[2][2];
    if (tr > 0) begin
      rad = tr + (longint'(1) << FRAC_BITS);
      s = longint'(int_sqrt(longint'(rad) << FRAC_BITS));
      comp[3] = s >>> 1;
      comp[0] = scaled_div(a[2][1] - a[1][2], s);
      comp[1] = scaled_div(a[0][2] - a[2][0], s);
      comp[2] = scaled_div(a[1][0] - a[0][1], s);
    end else begin
      i = 0;
      if (a[1][1] > a[0][0]) i = 1;
      if (a[2][2] > a[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = a[i][i] - a[j][j] - a[k][k] + (longint'(1) << FRAC_BITS);
      if (rad <= 0) begin
        res.bad = 1'b1;
      end else begin
        s = longint'(int_sqrt(longint'(rad) << FRAC_BITS));
        comp[i] = s >>> 1;
        comp[3] = scaled_div(a[k][j] - a[j][k], s);
        comp[j] = scaled_div(a[j][i] + a[i][j], s);
        comp[k] = scaled_div(a[k][i] + a[i][k], s);
      end
    end
    res.x = clamp16(comp[0]);
    res.y = clamp16(comp[1]);
    res.z = clamp16(comp[2]);
    res.w = clamp16(comp[3]);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    longint a[3][3];
    quat_t want;
    if (!rst && in_valid && in_ready) begin
      a = '{'{m00, m01, m02}, '{m10, m11, m12}, '{m20, m21, m22}};
      expected_quats.push_back(predict_quat(a));
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = expected_quats.pop_front();
        if (quat_x !== want.x) report_mismatch("quat_x", quat_x, want.x);
        if (quat_y !== want.y) report_mismatch("quat_y", quat_y, want.y);
        if (quat_z !== want.z) report_mismatch("quat_z", quat_z, want.z);
        if (quat_w !== want.w) report_mismatch("quat_w", quat_w, want.w);
        if (invalid !== want.bad) report_mismatch("invalid", invalid, want.bad);
      end
    end
  end

endmodule

// File: tb/sv/rotation_matrix_to_quaternion_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test
// Streams directed and random matrices through the block with random gaps
// and output stalls, including one long stall, and reports the verdict.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
  import rmq_pkg::*;

  localparam int ONE = 1 << 14;
  localparam int RANDOM_BEATS = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [DATA_W-1:0] mat[9];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [DATA_W-1:0] quat_x, quat_y, quat_z, quat_w;
  logic invalid;
  int fail_count;
  int pending;

  always #1 clk = ~clk;

  initial for (int n = 0; n < 9; n++) mat[n] = '0;

  rotation_matrix_to_quaternion u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .m00(mat[0]), .m01(mat[1]), .m02(mat[2]),
    .m10(mat[3]), .m11(mat[4]), .m12(mat[5]),
    .m20(mat[6]), .m21(mat[7]), .m22(mat[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .invalid(invalid)
  );

  rmq_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .m00(mat[0]), .m01(mat[1]), .m02(mat[2]),
    .m10(mat[3]), .m11(mat[4]), .m12(mat[5]),
    .m20(mat[6]), .m21(mat[7]), .m22(mat[8]),
    .out_valid(out_valid), .out_ready(out_ready),
    .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z), .quat_w(quat_w),
    .invalid(invalid),
    .fail_count(fail_count), .pending(pending)
  );

  // send one matrix after a random gap (none when no_gap is set), hold until accepted
  task automatic send_matrix(input logic signed [DATA_W-1:0] v[9], input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    mat = v;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] near(int center, int spread);
    int v;
    v = center + $signed($urandom_range(0, 2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[DATA_W-1:0];
  endfunction

  // rough rotation: a permuted signed identity plus small noise
  task automatic make_rotation(output logic signed [DATA_W-1:0] v[9]);
    int p[3];
    int t, r;
    p = '{0, 1, 2};
    for (int n = 2; n > 0; n--) begin
      r = $urandom_range(0, n);
      t = p[n]; p[n] = p[r]; p[r] = t;
    end
    for (int n = 0; n < 9; n++) v[n] = near(0, 6000);
    for (int n = 0; n < 3; n++)
      v[n * 3 + p[n]] = near($urandom_range(0, 1) ? ONE : -ONE, 6000);
  endtask

  // output side: random stalls, one long hold-off partway through
  initial begin
    int stall;
    int beats;
    beats = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (beats == 300) stall = 400;
      else if ($urandom_range(0, 3) == 0) stall = 0;
      else stall = $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      beats++;
      @(negedge clk);
    end
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    logic signed [DATA_W-1:0] v[9];
    int drain;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // identity, zero matrix, field extremes
    v = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}; send_matrix(v, 0);
    v = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(v, 0);
    for (int n = 0; n < 9; n++) v[n] = 16'sh7fff;
    send_matrix(v, 0);
    for (int n = 0; n < 9; n++) v[n] = 16'sh8000;
    send_matrix(v, 0);
    v = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
          16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
    send_matrix(v, 0);
    v = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
          16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    send_matrix(v, 0);
    // pivot on each axis (180 degree turns)
    v = '{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; send_matrix(v, 0);
    v = '{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}; send_matrix(v, 0);
    v = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}; send_matrix(v, 0);
    // diagonal ties
    v = '{-100, 5, 7, 9, -100, 11, 13, 15, -100}; send_matrix(v, 0);
    v = '{-200, 5, 7, 9, -100, 11, 13, 15, -100}; send_matrix(v, 0);
    // non-positive traces with a positive pivot radicand
    v = '{0, 0, 0, 0, 0, 0, 0, 0, -ONE}; send_matrix(v, 0);
    v = '{-ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}; send_matrix(v, 0);
    v = '{1 - ONE, 0, 0, 0, 0, 0, 0, 0, 0}; send_matrix(v, 0);
    // trace exactly 1 and trace 0 boundary
    v = '{1, 300, -300, -300, 0, 300, 300, -300, 0}; send_matrix(v, 0);
    v = '{1, 300, -300, -300, -1, 300, 300, -300, 0}; send_matrix(v, 0);
    // saturating quotients
    v = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, 16'sh8001};
    send_matrix(v, 0);

    for (int b = 0; b < RANDOM_BEATS; b++) begin
      case ($urandom_range(0, 9))
        0, 1: for (int n = 0; n < 9; n++) v[n] = DATA_W'($urandom());
        2: for (int n = 0; n < 9; n++) v[n] = near(0, 20000);
        default: make_rotation(v);
      endcase
      send_matrix(v, b % 200 < 40);
    end
    in_valid <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/rmq_pkg.sv
hdl/rotation_matrix_to_quaternion.sv
tb/sv/rmq_checker.sv
tb/sv/rotation_matrix_to_quaternion_test.sv
